/* src/uer_pkg.sv */
// Package for the ultrasonic echo ranger.
// Holds the transaction structs, request and result codes and arithmetic constants.
// No dependencies; every other file of the block imports it.
package uer_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TEMP  = 2'd2;

	localparam logic KIND_DIST = 1'b0;
	localparam logic KIND_VEL  = 1'b1;

	localparam int TICK_W = 16;
	localparam int VEL_W  = 13;
	localparam int DIST_W = 14;
	localparam int PROD_W = TICK_W + VEL_W;

	localparam logic [VEL_W-1:0]  VEL_BASE      = 13'd3315;
	localparam logic [VEL_W-1:0]  VEL_RESET     = 13'd3453;
	localparam logic [VEL_W-1:0]  VEL_MAX       = 13'd4845;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd17000;
	localparam logic [DIST_W-1:0] DIST_MAX      = 14'd16383;

	// Division by 20000 is done as a shift by five and a division by 625.
	// Products at or above 16384 * 20000 saturate.
	localparam logic [PROD_W-1:0] PROD_SAT = 29'd327680000;
	localparam int                DIV_SHIFT = 5;
	localparam int                QUOT_W    = 15;
	localparam int                RECIP_SHIFT = 24;
	localparam logic [14:0]       RECIP_625 = 15'd26843;
	localparam logic [9:0]        DIV_625   = 10'd625;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        echo_level;
		logic [15:0] temp_raw;
	} uer_req_t;

	typedef struct packed {
		logic              result_kind;
		logic [DIST_W-1:0] distance_tenth_cm;
		logic              echo_found;
		logic [VEL_W-1:0]  sound_velocity;
	} uer_rsp_t;

	typedef struct packed {
		logic              result_kind;
		logic              echo_found;
		logic [VEL_W-1:0]  sound_velocity;
		logic [PROD_W-1:0] product;
	} uer_work_t;

	typedef struct packed {
		logic armed;
		logic echo_seen_high;
	} uer_status_t;

endpackage

/* src/uer_ctrl.sv */
// Measurement control for the ultrasonic echo ranger: timeout register, arming,
// echo edge tracking, elapsed count, sound velocity and the velocity-time product.
// Depends on uer_pkg.
module uer_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  uer_pkg::uer_req_t   req_s1,
	input  logic                fire,
	output logic                emit,
	output uer_pkg::uer_work_t  work,
	output uer_pkg::uer_status_t status
);
	import uer_pkg::*;

	logic [TICK_W-1:0] timeout_q;
	logic              armed_q;
	logic              seen_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [VEL_W-1:0]  velocity_q;

	logic              armed_d;
	logic              seen_d;
	logic [TICK_W-1:0] elapsed_d;
	logic [VEL_W-1:0]  velocity_d;
	logic [TICK_W-1:0] el_inc;
	logic [VEL_W-1:0]  temp_vel;
	logic [PROD_W-1:0] dist_prod;

	assign el_inc    = (elapsed_q != {TICK_W{1'b1}}) ? elapsed_q + 16'd1 : elapsed_q;
	assign temp_vel  = VEL_BASE + VEL_W'(req_s1.temp_raw[11:4]) * 13'd6;
	assign dist_prod = PROD_W'(velocity_q) * PROD_W'(el_inc);

	always_comb begin
		armed_d    = armed_q;
		seen_d     = seen_q;
		elapsed_d  = elapsed_q;
		velocity_d = velocity_q;
		emit       = 1'b0;
		work.result_kind    = KIND_DIST;
		work.echo_found     = 1'b0;
		work.sound_velocity = velocity_q;
		work.product        = '0;
		unique case (req_s1.req_type)
			REQ_START: begin
				elapsed_d = '0;
				seen_d    = 1'b0;
				armed_d   = 1'b1;
			end
			REQ_TEMP: begin
				velocity_d          = temp_vel;
				emit                = 1'b1;
				work.result_kind    = KIND_VEL;
				work.sound_velocity = temp_vel;
			end
			REQ_TICK: begin
				if (armed_q) begin
					elapsed_d = el_inc;
					if (req_s1.echo_level) begin
						seen_d = 1'b1;
					end
					if (!req_s1.echo_level && seen_q) begin
						emit            = 1'b1;
						work.echo_found = 1'b1;
						work.product    = dist_prod;
						armed_d         = 1'b0;
						seen_d          = 1'b0;
					end else if (el_inc >= timeout_q) begin
						emit    = 1'b1;
						armed_d = 1'b0;
						seen_d  = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			seen_q     <= 1'b0;
			elapsed_q  <= '0;
			velocity_q <= VEL_RESET;
		end else if (fire) begin
			armed_q    <= armed_d;
			seen_q     <= seen_d;
			elapsed_q  <= elapsed_d;
			velocity_q <= velocity_d;
		end
	end

	assign status.armed          = armed_q;
	assign status.echo_seen_high = seen_q;

endmodule

/* src/uer_div.sv */
// Constant divider for the ultrasonic echo ranger: product / 20000 with saturation.
// A reciprocal estimate is registered, then corrected by one compare and add.
// Depends on uer_pkg.
module uer_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic [uer_pkg::PROD_W-1:0]  product,
	output logic [uer_pkg::DIST_W-1:0]  distance
);
	import uer_pkg::*;

	localparam int X_W = PROD_W - DIV_SHIFT;

	logic [X_W-1:0]              x;
	logic [X_W+QUOT_W-1:0]       est_full;
	logic [X_W-1:0]              x_s3;
	logic [QUOT_W-1:0]           q0_s3;
	logic                        sat_s3;
	logic [X_W:0]                back;
	logic [X_W:0]                rem;
	logic [QUOT_W:0]             quot;

	assign x        = product[PROD_W-1:DIV_SHIFT];
	assign est_full = (X_W+QUOT_W)'(x) * (X_W+QUOT_W)'(RECIP_625);

	always_ff @(posedge clk) begin
		if (load) begin
			x_s3   <= x;
			q0_s3  <= est_full[RECIP_SHIFT +: QUOT_W];
			sat_s3 <= (product >= PROD_SAT);
		end
	end

	// The estimate is never above the true quotient and at most one below it.
	assign back     = (X_W+1)'(q0_s3) * (X_W+1)'(DIV_625);
	assign rem      = {1'b0, x_s3} - back;
	assign quot     = {1'b0, q0_s3} + (QUOT_W+1)'(rem >= (X_W+1)'(DIV_625));
	assign distance = sat_s3 ? DIST_MAX : quot[DIST_W-1:0];

endmodule

/* src/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger.
// Holds the input, pipeline and result registers and the valid/stall handshakes.
// Depends on uer_pkg, uer_ctrl and uer_div.
//
// Request channel: req_valid, req_stall and the req struct. A start request clears
// the elapsed count and arms a measurement; tick requests, one per microsecond, count
// and sample the echo level; a temperature request updates the sound velocity.
// Response channel: rsp_valid, rsp_stall and the rsp struct. A distance transaction
// follows the echo fall or the timeout; a velocity transaction follows every
// temperature request. Starts and ignored ticks produce no response.
// One request is accepted per cycle while req_stall is low. The state update is made
// when the request leaves the input register, and a response reaches rsp by way of the
// input register, product register, quotient estimate register and result register.
// The velocity-time product multiplier and the constant division by 20000 set the
// stage split. Each stage moves on when the next one is empty or moving, so the
// block keeps accepting while a finished response waits in the result register.
// A stalled response holds; backpressure reaches req_stall only once all stages fill.
// The timeout register is written through cfg_we and cfg_wdata, with reset value 17000.
// Reset clears the pipeline, disarms and sets the velocity to 3453 (0.1 m/s).
module ultrasonic_echo_ranger (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  uer_pkg::uer_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output uer_pkg::uer_rsp_t rsp,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);
	import uer_pkg::*;

	uer_req_t    req_s1;
	uer_work_t   work;
	uer_work_t   work_s2;
	uer_status_t status;
	logic        emit;
	logic        v1_q;
	logic        v2_q;
	logic        v3_q;
	logic        vo_q;
	logic        kind_s3;
	logic        found_s3;
	logic [VEL_W-1:0]  vel_s3;
	logic [DIST_W-1:0] distance;
	uer_rsp_t    rsp_q;
	logic        req_acc;
	logic        out_rdy;
	logic        rdy3;
	logic        rdy2;
	logic        adv1;
	logic        adv2;
	logic        adv3;

	assign out_rdy   = !vo_q || !rsp_stall;
	assign rdy3      = !v3_q || out_rdy;
	assign rdy2      = !v2_q || rdy3;
	assign adv1      = v1_q && (!emit || rdy2);
	assign adv2      = v2_q && rdy3;
	assign adv3      = v3_q && out_rdy;
	assign req_stall = v1_q && !adv1;
	assign req_acc   = req_valid && !req_stall;

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_s1    (req_s1),
		.fire      (adv1),
		.emit      (emit),
		.work      (work),
		.status    (status)
	);

	uer_div u_div (
		.clk      (clk),
		.load     (adv2),
		.product  (work_s2.product),
		.distance (distance)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (req_acc) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1 && emit) begin
				v2_q <= 1'b1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				v3_q <= 1'b1;
			end else if (adv3) begin
				v3_q <= 1'b0;
			end
			if (out_rdy) begin
				vo_q <= adv3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (adv1 && emit) begin
			work_s2 <= work;
		end
		if (adv2) begin
			kind_s3  <= work_s2.result_kind;
			found_s3 <= work_s2.echo_found;
			vel_s3   <= work_s2.sound_velocity;
		end
		if (adv3) begin
			rsp_q.result_kind       <= kind_s3;
			rsp_q.distance_tenth_cm <= distance;
			rsp_q.echo_found        <= found_s3;
			rsp_q.sound_velocity    <= vel_s3;
		end
	end

	assign rsp_valid = vo_q;
	assign rsp       = rsp_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v1_q)
		else $error("request stalled with an empty input register");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && req_s1.req_type == REQ_START |=> status.armed && !status.echo_seen_high)
		else $error("start transaction did not arm the measurement");

	a_no_echo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.echo_found |-> rsp.distance_tenth_cm == '0)
		else $error("distance reported without an echo");

	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_VEL
			|-> rsp.sound_velocity >= VEL_BASE && rsp.sound_velocity <= VEL_MAX
			&& !rsp.echo_found)
		else $error("velocity transaction out of range");

endmodule
